### sv/ite_pkg.sv
package ite_pkg;

    // Command codes of an input item.
    localparam logic [2:0] CMD_MSI      = 3'd0;
    localparam logic [2:0] CMD_MOVE     = 3'd1;
    localparam logic [2:0] CMD_MAPD     = 3'd2;
    localparam logic [2:0] CMD_MAPC     = 3'd3;
    localparam logic [2:0] CMD_MAPTI    = 3'd4;
    localparam logic [2:0] CMD_NOP      = 3'd5;

    // Result status codes.
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_UNMAPPED  = 3'd1;
    localparam logic [2:0] ST_INV_COLL  = 3'd2;
    localparam logic [2:0] ST_RANGE     = 3'd3;
    localparam logic [2:0] ST_UNSUP     = 3'd4;

    // Configuration register indexes.
    localparam logic REG_DEV_BASE  = 1'b0;
    localparam logic REG_COLL_BASE = 1'b1;

    localparam logic [63:0] COLL_INVALID = '1;

    // Classified operation passed from the front part to the back part.
    typedef enum logic [2:0] {
        OP_MSI   = 3'd0,
        OP_MOVE  = 3'd1,
        OP_MAPD  = 3'd2,
        OP_MAPC  = 3'd3,
        OP_MAPTI = 3'd4,
        OP_DONE  = 3'd5
    } t_op;

    typedef struct packed {
        t_op         op;
        logic [2:0]  status;
        logic [15:0] device_id;
        logic [31:0] evt_index;
        logic [15:0] collection_id;
        logic [31:0] phys_intid;
        logic [63:0] map_word;
    } t_job;

endpackage

### sv/ite_front.sv
module ite_front
    import ite_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [2:0]  i_command,
    input  logic [15:0] i_device_id,
    input  logic [31:0] i_evt_index,
    input  logic [15:0] i_collection_id,
    input  logic [31:0] i_phys_intid,
    input  logic [31:0] i_redist_target,
    input  logic [51:0] i_itt_base,
    input  logic        i_map_valid,
    output logic        o_job_valid,
    input  logic        i_job_take,
    output t_job        o_job
);

    // Two-entry queue between classification and execution.
    t_job       r_q [2];
    logic [1:0] r_cnt;
    logic       r_wp, r_rp;
    t_job       n_job;
    logic       push, pop;

    // Classify the command and build the word that map commands write.
    always_comb begin
        n_job = '0;
        n_job.device_id     = i_device_id;
        n_job.evt_index     = i_evt_index;
        n_job.collection_id = i_collection_id;
        n_job.phys_intid    = i_phys_intid;
        n_job.status        = ST_OK;
        case (i_command)
            CMD_MSI:   n_job.op = OP_MSI;
            CMD_MOVE:  n_job.op = OP_MOVE;
            CMD_MAPD: begin
                n_job.op = OP_MAPD;
                n_job.map_word = i_map_valid ? {12'd0, i_itt_base[51:8], 8'd0} : 64'd0;
            end
            CMD_MAPC: begin
                n_job.op = OP_MAPC;
                n_job.map_word = i_map_valid ? {32'd0, i_redist_target} : COLL_INVALID;
            end
            CMD_MAPTI: n_job.op = OP_MAPTI;
            CMD_NOP:   n_job.op = OP_DONE;
            default: begin
                n_job.op     = OP_DONE;
                n_job.status = ST_UNSUP;
            end
        endcase
    end

    assign o_stall     = r_cnt[1];
    assign push        = i_valid && !r_cnt[1];
    assign o_job_valid = r_cnt != 2'd0;
    assign pop         = o_job_valid && i_job_take;
    assign o_job       = r_q[r_rp];

    // Queue pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
        end else begin
            if (push) r_wp <= !r_wp;
            if (pop)  r_rp <= !r_rp;
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end

    // Queue payload.
    always_ff @(posedge i_clk) begin
        if (push) r_q[r_wp] <= n_job;
    end

endmodule

### sv/ite_back.sv
module ite_back
    import ite_pkg::*;
#(
    parameter int STORE_WORDS = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [47:0] i_cfg_data,
    input  logic        i_job_valid,
    output logic        o_job_take,
    input  t_job        i_job,
    output logic        o_busy,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_lpi_fire,
    output logic [31:0] o_lpi_intid,
    output logic [3:0]  o_lpi_target,
    output logic [2:0]  o_status
);

    localparam int AW = $clog2(STORE_WORDS);

    typedef enum logic [7:0] {
        S_CLEAR = 8'b0000_0001,
        S_IDLE  = 8'b0000_0010,
        S_DEV   = 8'b0000_0100,
        S_TRN   = 8'b0000_1000,
        S_COL1  = 8'b0001_0000,
        S_COL2  = 8'b0010_0000,
        S_FIN   = 8'b0100_0000,
        S_OUT   = 8'b1000_0000
    } t_state;

    t_state      r_state, n_state;
    logic [63:0] r_mem [STORE_WORDS];
    logic [47:0] r_dev_base, r_coll_base;
    logic [AW-1:0] r_clr;
    t_job        r_job;
    logic [63:0] r_dent, r_tent, r_c1, r_rd;
    logic        r_rd_hit, r_hit;
    logic [AW-1:0] r_waddr;
    logic        r_fire;
    logic [31:0] r_intid;
    logic [3:0]  r_tgt;
    logic [2:0]  r_st;

    // Address lookup: word index of base + 8*index, with an in-store flag.
    logic [63:0] lk_base, lk_index;
    logic [AW-1:0] lk_addr;
    logic        lk_hit;
    logic [64:0] lk_sum;
    logic [63:0] rd_word;
    logic        rd_en, wr_en;
    logic [AW-1:0] wr_addr;
    logic [63:0] wr_data;

    // Read address from the new job when idle, the last word read, or the held job.
    always_comb begin
        lk_base  = 64'd0;
        lk_index = 64'd0;
        case (r_state)
            S_IDLE: begin
                lk_base = {16'd0, r_dev_base[47:12], 12'd0};
                lk_index = {48'd0, i_job.device_id};
                if (i_job.op == OP_MAPC) begin
                    lk_base = {16'd0, r_coll_base[47:12], 12'd0};
                    lk_index = {48'd0, i_job.collection_id};
                end
            end
            S_DEV: begin
                lk_base = rd_word;
                lk_index = {32'd0, r_job.evt_index};
            end
            S_TRN: begin
                lk_base = {16'd0, r_coll_base[47:12], 12'd0};
                lk_index = {48'd0, rd_word[47:32]};
            end
            default: begin
                lk_base = {16'd0, r_coll_base[47:12], 12'd0};
                lk_index = {48'd0, r_job.collection_id};
            end
        endcase
        lk_sum  = {4'd0, lk_base[63:3]} + {1'b0, lk_index};
        lk_hit  = ({3'd0, lk_base[63:3]} < 64'(STORE_WORDS)) &&
                  (lk_sum < 65'(STORE_WORDS));
        lk_addr = lk_sum[AW-1:0];
    end

    // The word last read, or the miss value if it was outside the store.
    // Collection words miss as invalid, device and translation words as zero.
    always_comb begin
        if (r_rd_hit) rd_word = r_rd;
        else if (r_state == S_COL1 || r_state == S_COL2 || r_state == S_FIN)
            rd_word = COLL_INVALID;
        else rd_word = 64'd0;
    end

    assign o_job_take = (r_state == S_IDLE) && i_job_valid;
    assign rd_en = (r_state == S_IDLE) || (r_state == S_DEV) ||
                   (r_state == S_TRN)  || (r_state == S_COL1);

    // Store writes: clearing pass, map commands, and move at the end.
    always_comb begin
        wr_en = 1'b0;
        wr_addr = r_waddr;
        wr_data = r_job.map_word;
        case (r_state)
            S_CLEAR: begin
                wr_en = 1'b1;
                wr_addr = r_clr;
                wr_data = 64'd0;
            end
            S_FIN: begin
                case (r_job.op)
                    OP_MAPD, OP_MAPC: wr_en = r_hit;
                    OP_MAPTI: begin
                        wr_en = r_hit && (r_dent != 64'd0);
                        wr_data = {16'd0, r_job.collection_id, r_job.phys_intid};
                    end
                    OP_MOVE: begin
                        wr_en = r_hit && (r_dent != 64'd0) && (r_tent != 64'd0) &&
                                (r_c1 != rd_word);
                        wr_data = {16'd0, r_job.collection_id, r_tent[31:0]};
                    end
                    default: wr_en = 1'b0;
                endcase
            end
            default: wr_en = 1'b0;
        endcase
    end

    // Single-ported table store.
    always_ff @(posedge i_clk) begin
        if (wr_en) r_mem[wr_addr] <= wr_data;
        else if (rd_en) r_rd <= r_mem[lk_addr];
    end

    // Sequencer: at most one store access per cycle.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: if (r_clr == AW'(STORE_WORDS - 1)) n_state = S_IDLE;
            S_IDLE: begin
                if (i_job_valid) begin
                    case (i_job.op)
                        OP_MSI, OP_MOVE, OP_MAPTI: n_state = S_DEV;
                        OP_MAPD, OP_MAPC: n_state = S_FIN;
                        default: n_state = S_OUT;
                    endcase
                end
            end
            S_DEV: n_state = (r_job.op == OP_MAPTI || rd_word == 64'd0) ? S_FIN : S_TRN;
            S_TRN: n_state = (rd_word == 64'd0) ? S_FIN : S_COL1;
            S_COL1: n_state = (r_job.op == OP_MOVE) ? S_COL2 : S_FIN;
            S_COL2: n_state = S_FIN;
            S_FIN: n_state = S_OUT;
            S_OUT: if (!i_stall) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_dev_base  <= '0;
            r_coll_base <= '0;
            r_rd_hit    <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_rd_hit <= lk_hit;
            if (r_state == S_CLEAR) r_clr <= r_clr + AW'(1);
            if (i_cfg_we) begin
                if (i_cfg_idx == REG_DEV_BASE) r_dev_base <= i_cfg_data;
                else r_coll_base <= i_cfg_data;
            end
        end
    end

    // Walk registers and result.
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_job <= i_job;
                r_hit <= lk_hit;
                r_waddr <= lk_addr;
                r_dent <= 64'd0;
                r_tent <= 64'd0;
                r_fire <= 1'b0;
                r_intid <= 32'd0;
                r_tgt <= 4'd0;
                r_st <= i_job.status;
            end
            S_DEV: begin
                r_dent <= rd_word;
                r_hit <= lk_hit;
                r_waddr <= lk_addr;
                if (r_job.op == OP_MSI && rd_word == 64'd0) r_st <= ST_UNMAPPED;
            end
            S_TRN: begin
                r_tent <= rd_word;
                if (r_job.op == OP_MSI && rd_word == 64'd0) r_st <= ST_UNMAPPED;
            end
            S_COL1: begin
                r_c1 <= rd_word;
                if (r_job.op == OP_MSI) begin
                    if (rd_word == COLL_INVALID) r_st <= ST_INV_COLL;
                    else if (rd_word >= 64'd16) r_st <= ST_RANGE;
                    else begin
                        r_fire <= 1'b1;
                        r_intid <= r_tent[31:0];
                        r_tgt <= rd_word[3:0];
                    end
                end
            end
            default: ;
        endcase
    end

    assign o_busy       = r_state != S_IDLE;
    assign o_valid      = r_state == S_OUT;
    assign o_lpi_fire   = r_fire;
    assign o_lpi_intid  = r_intid;
    assign o_lpi_target = r_tgt;
    assign o_status     = r_st;

endmodule

### sv/interrupt_translation_engine.sv
// Channel  | Handshake            | Payload
// input    | i_valid / o_stall    | i_command .. i_map_valid
// result   | o_valid / i_stall    | o_lpi_fire, o_lpi_intid, o_lpi_target, o_status
// config   | i_cfg_we             | i_cfg_idx, i_cfg_data
// An msi item makes four store reads in the back part, one at a time since the store
// has a single port; a new item is taken only once the back part is idle again.
// After reset a clearing pass writes zero to every store word; items wait.
// A two-entry queue lets the front accept while the back works or is stalled.
module interrupt_translation_engine
    import ite_pkg::*;
#(
    parameter int STORE_WORDS = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [47:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [2:0]  i_command,
    input  logic [15:0] i_device_id,
    input  logic [31:0] i_evt_index,
    input  logic [15:0] i_collection_id,
    input  logic [31:0] i_phys_intid,
    input  logic [31:0] i_redist_target,
    input  logic [51:0] i_itt_base,
    input  logic        i_map_valid,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_lpi_fire,
    output logic [31:0] o_lpi_intid,
    output logic [3:0]  o_lpi_target,
    output logic [2:0]  o_status
);

    logic job_valid, job_take, busy;
    t_job job;

    ite_front u_front (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .i_command, .i_device_id,
        .i_evt_index, .i_collection_id, .i_phys_intid, .i_redist_target,
        .i_itt_base, .i_map_valid,
        .o_job_valid(job_valid), .i_job_take(job_take), .o_job(job)
    );

    ite_back #(.STORE_WORDS(STORE_WORDS)) u_back (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_idx, .i_cfg_data,
        .i_job_valid(job_valid), .o_job_take(job_take), .i_job(job),
        .o_busy(busy), .o_valid, .i_stall, .o_lpi_fire, .o_lpi_intid,
        .o_lpi_target, .o_status
    );

`ifndef NO_ASSERTIONS
    // A job is only taken when the back part is idle.
    a_take_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        job_take |-> !busy) else $error("job taken while busy");
    // A fired LPI always reports status ok.
    a_fire_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_lpi_fire) |-> (o_status == ST_OK)) else $error("fire with error");
    // Without a fire, the LPI fields read zero.
    a_nofire_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_lpi_fire) |-> (o_lpi_intid == 32'd0 && o_lpi_target == 4'd0))
        else $error("stale lpi fields");
`endif

endmodule
